FILE: rtl/core/u2s_pkg.sv
// ----------------------------------------------------------------------------
// u2s_pkg
// Shared types and constants of the UTF-8 to double-byte code page transcoder.
// ----------------------------------------------------------------------------
package u2s_pkg;

  // input transaction: a UTF-8 byte or one code table write
  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic [15:0] table_index;
    logic [15:0] table_value;
  } in_item_t;

  // result transaction: one byte of the target encoding
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // input modes
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // what one decoded step asks of the back end
  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_LOOKUP,
    SLOT_ZERO
  } slot_kind_e;

  typedef struct packed {
    slot_kind_e  kind;
    logic [15:0] cp;
  } slot_t;

  // queue entry between decoder and table back end
  // for a table write, slot_a.cp carries the index
  typedef struct packed {
    logic        is_write;
    logic [15:0] wr_value;
    slot_t       slot_a;
    slot_t       slot_b;
  } op_t;

  typedef enum logic [1:0] {
    BK_ISSUE,
    BK_DATA,
    BK_LOW
  } back_state_e;

  // replacement code point for malformed input
  localparam logic [15:0] QMARK_CP = 16'h003F;

  // code table geometry
  localparam int unsigned TABLE_AW    = 16;
  localparam int unsigned TABLE_DEPTH = 1 << TABLE_AW;

  // op queue between front and back
  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  // result queue at the output
  localparam int unsigned OUTQ_DEPTH = 2;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

endpackage

FILE: rtl/core/utf8_to_shift_jis_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_shift_jis_transcoder_unit
// UTF-8 to double-byte code page transcoder with a loadable 64K code table.
// ----------------------------------------------------------------------------
// The decoder takes one input transaction per cycle while its four-entry op
// queue has room. For each code-table lookup the back end first reads the
// table, then puts out the byte, plus a further step for the low byte when
// the entry is a two-byte code; a terminator and a table write are handled
// in the issue state alone. The back end finishes each byte before it starts
// the next lookup. The code table is not cleared at reset: every entry that
// is looked up must have been written first. Results wait in a two-entry
// output queue, so the back end keeps working while the consumer stalls,
// until the queue fills.
module utf8_to_shift_jis_transcoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  u2s_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output u2s_pkg::out_item_t out_item_o
);
  import u2s_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  op_t  q_item, q_head;

  // decoder
  u2s_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_item_o  (q_item),
    .q_full_i  (q_full)
  );

  // op queue
  u2s_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // table back end
  u2s_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_head_i   (q_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

  // no entry pushed into a full op queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("op queue overflow");

  // back end never releases an entry that is not there
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("op queue underflow");

  // an accepted terminator always reaches the back end
  a_term_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_item_i.mode == MODE_DATA && in_item_i.data_byte == 8'h00)
    |-> q_push) else $error("terminator lost");

  // an accepted table write always reaches the back end
  a_write_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_item_i.mode == MODE_WRITE) |-> q_push)
    else $error("table write lost");

endmodule

FILE: rtl/core/u2s_front.sv
// ----------------------------------------------------------------------------
// u2s_front
// UTF-8 decoder: accepts input transactions, keeps the sequence state and
// turns each byte into at most one queue entry of lookups and terminators.
// ----------------------------------------------------------------------------
module u2s_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2s_pkg::in_item_t in_item_i,
  output logic              full_o,
  output logic              q_push_o,
  output u2s_pkg::op_t      q_item_o,
  input  logic              q_full_i
);
  import u2s_pkg::*;

  logic [1:0]  be_q, be_d;
  logic [15:0] pc_q, pc_d;
  logic        sk_q, sk_d;
  logic        accept;
  op_t         op;
  logic        has_op;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  // decode one byte against the pending sequence state
  always_comb begin
    logic [7:0] b;
    logic       cont;
    logic       done;
    logic       have_a;
    slot_t      s_new;
    logic       add;

    b      = in_item_i.data_byte;
    cont   = (b[7:6] == 2'b10);
    done   = 1'b0;
    have_a = 1'b0;
    add    = 1'b0;
    s_new  = '{kind: SLOT_NONE, cp: '0};
    be_d   = be_q;
    pc_d   = pc_q;
    sk_d   = sk_q;
    op     = '{is_write: 1'b0, wr_value: '0,
               slot_a: '{kind: SLOT_NONE, cp: '0},
               slot_b: '{kind: SLOT_NONE, cp: '0}};
    has_op = 1'b0;

    if (in_item_i.mode == MODE_WRITE) begin
      op.is_write  = 1'b1;
      op.wr_value  = in_item_i.table_value;
      op.slot_a.cp = in_item_i.table_index;
      has_op       = 1'b1;
    end else begin
      // pending multi-byte sequence
      if (be_q != 2'd0) begin
        if (cont) begin
          done = 1'b1;
          if (be_q == 2'd2) begin
            pc_d = pc_q | {4'h0, b[5:0], 6'h00};
            be_d = 2'd1;
          end else begin
            op.slot_a = '{kind: SLOT_LOOKUP, cp: pc_q | {10'h000, b[5:0]}};
            have_a    = 1'b1;
            be_d      = 2'd0;
            pc_d      = '0;
          end
        end else begin
          // truncated sequence flushes as replacement
          op.slot_a = '{kind: SLOT_LOOKUP, cp: QMARK_CP};
          have_a    = 1'b1;
          be_d      = 2'd0;
          pc_d      = '0;
        end
      end

      // swallowing stray continuations
      if (!done && sk_q) begin
        if (cont) begin
          done = 1'b1;
        end else begin
          sk_d = 1'b0;
        end
      end

      // byte handled afresh
      if (!done) begin
        if (b == 8'h00) begin
          s_new = '{kind: SLOT_ZERO, cp: '0};
          add   = 1'b1;
          be_d  = 2'd0;
          pc_d  = '0;
          sk_d  = 1'b0;
        end else if (!b[7]) begin
          s_new = '{kind: SLOT_LOOKUP, cp: {8'h00, b}};
          add   = 1'b1;
        end else if (!b[6]) begin
          s_new = '{kind: SLOT_LOOKUP, cp: QMARK_CP};
          add   = 1'b1;
          sk_d  = 1'b1;
        end else if (!b[5]) begin
          pc_d = {5'h00, b[4:0], 6'h00};
          be_d = 2'd1;
        end else if (!b[4]) begin
          pc_d = {b[3:0], 12'h000};
          be_d = 2'd2;
        end else begin
          s_new = '{kind: SLOT_LOOKUP, cp: QMARK_CP};
          add   = 1'b1;
          sk_d  = 1'b1;
        end
      end

      if (add) begin
        if (have_a) begin
          op.slot_b = s_new;
        end else begin
          op.slot_a = s_new;
          have_a    = 1'b1;
        end
      end
      has_op = have_a;
    end
  end

  assign q_push_o = accept && has_op;
  assign q_item_o = op;

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q <= 2'd0;
      pc_q <= '0;
      sk_q <= 1'b0;
    end else if (accept) begin
      be_q <= be_d;
      pc_q <= pc_d;
      sk_q <= sk_d;
    end
  end

endmodule

FILE: rtl/core/u2s_opq.sv
// ----------------------------------------------------------------------------
// u2s_opq
// Short queue of decoded entries between the decoder and the table back end.
// ----------------------------------------------------------------------------
module u2s_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  u2s_pkg::op_t item_i,
  output logic         full_o,
  input  logic         pop_i,
  output u2s_pkg::op_t head_o,
  output logic         empty_o
);
  import u2s_pkg::*;

  op_t                  mem_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + OPQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - OPQ_CNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + OPQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + OPQ_PTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/u2s_back.sv
// ----------------------------------------------------------------------------
// u2s_back
// Table back end: owns the code table memory, carries out table writes and
// lookups from the op queue and emits result bytes into a small output queue.
// ----------------------------------------------------------------------------
module u2s_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u2s_pkg::op_t       q_head_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output u2s_pkg::out_item_t out_item_o
);
  import u2s_pkg::*;

  logic [15:0]           code_table_q [TABLE_DEPTH];
  logic [15:0]           rd_data_q;
  back_state_e           state_q, state_d;
  logic                  sel_q, sel_d;
  slot_t                 cur;
  logic                  is_final;
  logic                  mem_we, mem_re;
  logic                  emit, adv;
  out_item_t             emit_item;

  out_item_t             outq_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owr_q, ord_q;
  logic [OUTQ_CNT_W-1:0] ocnt_q, ocnt_d;
  logic                  out_space, out_pop;

  assign cur       = sel_q ? q_head_i.slot_b : q_head_i.slot_a;
  assign is_final  = sel_q || (q_head_i.slot_b.kind == SLOT_NONE);
  assign out_space = (ocnt_q != OUTQ_CNT_W'(OUTQ_DEPTH));
  assign out_pop   = pop_i && !empty_o;

  // sequencer: next state, table access and byte emission
  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    emit      = 1'b0;
    adv       = 1'b0;
    emit_item = '{out_byte: '0, last_of_run: 1'b0};
    case (state_q)
      BK_ISSUE: begin
        if (!q_empty_i) begin
          if (q_head_i.is_write) begin
            mem_we  = 1'b1;
            q_pop_o = 1'b1;
          end else begin
            case (cur.kind)
              SLOT_ZERO: begin
                if (out_space) begin
                  emit      = 1'b1;
                  emit_item = '{out_byte: 8'h00, last_of_run: is_final};
                  adv       = 1'b1;
                end
              end
              SLOT_LOOKUP: begin
                mem_re  = 1'b1;
                state_d = BK_DATA;
              end
              default: adv = 1'b1;
            endcase
          end
        end
      end
      BK_DATA: begin
        if (out_space) begin
          emit = 1'b1;
          if (rd_data_q[15:8] != 8'h00) begin
            emit_item = '{out_byte: rd_data_q[15:8], last_of_run: 1'b0};
            state_d   = BK_LOW;
          end else begin
            emit_item = '{out_byte: rd_data_q[7:0], last_of_run: is_final};
            adv       = 1'b1;
            state_d   = BK_ISSUE;
          end
        end
      end
      BK_LOW: begin
        if (out_space) begin
          emit      = 1'b1;
          emit_item = '{out_byte: rd_data_q[7:0], last_of_run: is_final};
          adv       = 1'b1;
          state_d   = BK_ISSUE;
        end
      end
      default: state_d = BK_ISSUE;
    endcase

    // step to the next slot or release the entry
    if (adv) begin
      if (is_final) begin
        q_pop_o = 1'b1;
        sel_d   = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_ISSUE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // code table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      code_table_q[q_head_i.slot_a.cp] <= q_head_i.wr_value;
    end
    if (mem_re) begin
      rd_data_q <= code_table_q[cur.cp];
    end
  end

  // output queue occupancy
  always_comb begin
    ocnt_d = ocnt_q;
    if (emit && !out_pop) begin
      ocnt_d = ocnt_q + OUTQ_CNT_W'(1);
    end else if (out_pop && !emit) begin
      ocnt_d = ocnt_q - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (emit) begin
        owr_q <= (owr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_q + OUTQ_PTR_W'(1);
      end
      if (out_pop) begin
        ord_q <= (ord_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_q + OUTQ_PTR_W'(1);
      end
    end
  end

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (emit) begin
      outq_q[owr_q] <= emit_item;
    end
  end

  assign empty_o    = (ocnt_q == '0);
  assign out_item_o = outq_q[ord_q];

endmodule
